// File: sv/ile_pkg.sv
// shared definitions for the indexed list engine
// widths, default capacity and command codes; no dependencies
package ile_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W       = 32;
   localparam int CMD_W        = 3;
   localparam int POS_W        = 5;
   localparam int COUNT_OUT_W  = 5;

   localparam int REQ_TDATA_W  = 40;
   localparam int RSP_TDATA_W  = 104;

   typedef enum logic [CMD_W-1:0] {
      OP_APPEND    = 3'd0,
      OP_PREPEND   = 3'd1,
      OP_DROP_LAST = 3'd2,
      OP_DROP_FRST = 3'd3,
      OP_READ      = 3'd4,
      OP_WRITE     = 3'd5,
      OP_INSERT    = 3'd6,
      OP_REMOVE    = 3'd7
   } op_type;

endpackage

// File: sv/ile_ram.sv
// generic single write, single read port ram with registered read data
// no dependencies
module ile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/indexed_list_engine_core.sv
// order: append, drop last, overwrite and refused requests go straight to the head and tail fetch,
// read first waits on its ram data, insert/prepend first move count-position entries up and
// remove/drop first count-1-position entries down; one request in flight, each element moved
// costs a read and a write of the entry ram, so shifting sets the rate
// the next request is taken while a finished response still waits on rsp_tready
// reset: synchronous active high, empties the list; entry ram is not cleared
module indexed_list_engine_core #(
   parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request: [2:0] command, [34:3] item_value, [39:35] position
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ile_pkg::REQ_TDATA_W-1:0] req_tdata,
   // response: [31:0] read_value, [63:32] head_value, [95:64] tail_value,
   // [100:96] entry_count, [103:101] zero
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ile_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // response user: [0] ok
   output logic                           rsp_tuser
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAP_RD,
      ST_GAP_WR,
      ST_CLOSE_RD,
      ST_CLOSE_WR,
      ST_READ_WAIT,
      ST_HEAD,
      ST_TAIL,
      ST_LAST
   } state_type;

   // request fields
   ile_pkg::op_type                   req_cmd;
   logic signed [ile_pkg::DATA_W-1:0] req_value;
   logic [ile_pkg::POS_W-1:0]         req_pos;

   assign req_cmd   = ile_pkg::op_type'(req_tdata[2:0]);
   assign req_value = req_tdata[34:3];
   assign req_pos   = req_tdata[39:35];

   // control state
   state_type                         state_ff, state_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // work registers
   logic [AW-1:0]                     idx_ff, idx_in;
   logic [AW-1:0]                     pos_ff, pos_in;
   logic signed [ile_pkg::DATA_W-1:0] val_ff, val_in;
   logic                              ok_ff, ok_in;
   logic signed [ile_pkg::DATA_W-1:0] rd_tmp_ff, rd_tmp_in;
   logic signed [ile_pkg::DATA_W-1:0] head_tmp_ff, head_tmp_in;

   // response registers
   logic                              rsp_ok_ff, rsp_ok_in;
   logic signed [ile_pkg::DATA_W-1:0] rsp_rd_ff, rsp_rd_in;
   logic signed [ile_pkg::DATA_W-1:0] rsp_head_ff, rsp_head_in;
   logic signed [ile_pkg::DATA_W-1:0] rsp_tail_ff, rsp_tail_in;
   logic [ile_pkg::COUNT_OUT_W-1:0]   rsp_count_ff, rsp_count_in;

   // entry ram ports
   logic                              ram_we, ram_re;
   logic [AW-1:0]                     ram_waddr, ram_raddr;
   logic [ile_pkg::DATA_W-1:0]        ram_wdata, ram_rdata;

   // shared index stepper: down while opening a gap, up while closing one
   logic                              step_down;
   logic [AW-1:0]                     idx_nb;

   logic                              accept;
   logic                              full, empty;
   logic [CMPW-1:0]                   count_ext, pos_ext;
   logic                              pos_lt_cnt, pos_le_cnt;
   logic                              cmd_ok;
   logic                              out_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   assign full       = (count_ff == CW'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign count_ext  = CMPW'(count_ff);
   assign pos_ext    = CMPW'(req_pos);
   assign pos_lt_cnt = (pos_ext < count_ext);
   assign pos_le_cnt = (pos_ext <= count_ext);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign step_down  = (state_ff == ST_GAP_RD) || (state_ff == ST_GAP_WR);
   assign idx_nb     = step_down ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));

   // acceptance check per command
   always_comb begin
      case (req_cmd)
         ile_pkg::OP_APPEND,
         ile_pkg::OP_PREPEND:   cmd_ok = !full;
         ile_pkg::OP_DROP_LAST,
         ile_pkg::OP_DROP_FRST: cmd_ok = !empty;
         ile_pkg::OP_INSERT:    cmd_ok = !full && pos_le_cnt;
         ile_pkg::OP_READ,
         ile_pkg::OP_WRITE,
         ile_pkg::OP_REMOVE:    cmd_ok = pos_lt_cnt;
         default:               cmd_ok = 1'b0;
      endcase
   end

   // sequencer next state, ram control and register updates
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      ok_in        = ok_ff;
      rd_tmp_in    = rd_tmp_ff;
      head_tmp_in  = head_tmp_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_head_in  = rsp_head_ff;
      rsp_tail_in  = rsp_tail_ff;
      rsp_count_in = rsp_count_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = idx_nb;

      // response taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ok_in     = cmd_ok;
               val_in    = req_value;
               pos_in    = AW'(req_pos);
               rd_tmp_in = '0;
               state_in  = ST_HEAD;
               if (cmd_ok) begin
                  case (req_cmd)
                     ile_pkg::OP_APPEND: begin
                        ram_we    = 1'b1;
                        ram_waddr = count_ff[AW-1:0];
                        ram_wdata = req_value;
                        count_in  = count_ff + CW'(1);
                     end
                     ile_pkg::OP_PREPEND: begin
                        pos_in   = '0;
                        idx_in   = count_ff[AW-1:0];
                        state_in = ST_GAP_RD;
                     end
                     ile_pkg::OP_INSERT: begin
                        idx_in   = count_ff[AW-1:0];
                        state_in = ST_GAP_RD;
                     end
                     ile_pkg::OP_DROP_LAST: begin
                        count_in = count_ff - CW'(1);
                     end
                     ile_pkg::OP_DROP_FRST: begin
                        idx_in   = '0;
                        state_in = ST_CLOSE_RD;
                     end
                     ile_pkg::OP_REMOVE: begin
                        idx_in   = AW'(req_pos);
                        state_in = ST_CLOSE_RD;
                     end
                     ile_pkg::OP_READ: begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(req_pos);
                        state_in  = ST_READ_WAIT;
                     end
                     ile_pkg::OP_WRITE: begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(req_pos);
                        ram_wdata = req_value;
                     end
                     default: begin
                        state_in = ST_HEAD;
                     end
                  endcase
               end
            end
         end
         // move entries up one place from the tail down to the gap
         ST_GAP_RD: begin
            if (idx_ff == pos_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff;
               ram_wdata = val_ff;
               count_in  = count_ff + CW'(1);
               state_in  = ST_HEAD;
            end else begin
               ram_re   = 1'b1;
               state_in = ST_GAP_WR;
            end
         end
         ST_GAP_WR: begin
            ram_we   = 1'b1;
            idx_in   = idx_nb;
            state_in = ST_GAP_RD;
         end
         // move entries down one place from the hole to the tail
         ST_CLOSE_RD: begin
            if ((CW'(idx_ff) + CW'(1)) == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = ST_HEAD;
            end else begin
               ram_re   = 1'b1;
               state_in = ST_CLOSE_WR;
            end
         end
         ST_CLOSE_WR: begin
            ram_we   = 1'b1;
            idx_in   = idx_nb;
            state_in = ST_CLOSE_RD;
         end
         ST_READ_WAIT: begin
            rd_tmp_in = ram_rdata;
            state_in  = ST_HEAD;
         end
         // fetch head then tail for the response
         ST_HEAD: begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_in  = ST_TAIL;
         end
         ST_TAIL: begin
            head_tmp_in = empty ? '0 : ram_rdata;
            ram_re      = 1'b1;
            ram_raddr   = AW'(count_ff - CW'(1));
            state_in    = ST_LAST;
         end
         // ram read data holds here until the response register is free
         ST_LAST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_rd_in    = rd_tmp_ff;
               rsp_head_in  = head_tmp_ff;
               rsp_tail_in  = empty ? '0 : ram_rdata;
               rsp_count_in = count_ext[ile_pkg::COUNT_OUT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      ok_ff        <= ok_in;
      rd_tmp_ff    <= rd_tmp_in;
      head_tmp_ff  <= head_tmp_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_head_ff  <= rsp_head_in;
      rsp_tail_ff  <= rsp_tail_in;
      rsp_count_ff <= rsp_count_in;
   end

   // entry storage
   ile_ram #(
      .WIDTH (ile_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_tail_ff, rsp_head_ff, rsp_rd_ff};

`ifndef SYNTHESIS
   // the list never grows past its capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // a gap is only opened in a list that has room
   a_gap_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GAP_RD || state_ff == ST_GAP_WR) |-> !full)
      else $error("gap opened in full list");

   // a hole is only closed in a non-empty list
   a_close_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLOSE_RD || state_ff == ST_CLOSE_WR) |-> !empty)
      else $error("hole closed in empty list");

   // a successful append grows the list by one at once
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == ile_pkg::OP_APPEND && cmd_ok)
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("append did not bump count");
`endif

endmodule

// File: dv/tb.sv
// testbench for indexed_list_engine_core: directed and random list commands, with a
// shadow list predicting every response; depends on ile_pkg and the core rtl only
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_CAP     = ile_pkg::CAPACITY_DEF;
   localparam int HOLDOFF_LEN  = 300;   // long receiver stall for the backpressure test
   localparam int SETTLE_WAIT  = 60;    // quiet time after the drain, before the result is printed
   localparam int DRAIN_LIMIT  = 20000;

   // one expected response, fields in the same order as the port comment
   typedef struct packed {
      logic        ok;
      logic [31:0] read_value;
      logic [31:0] head_value;
      logic [31:0] tail_value;
      logic [4:0]  entry_count;
   } list_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ile_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ile_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;

   // shadow copy of the list, updated when a request is accepted
   logic [31:0]     shadow_list [LIST_CAP];
   int              shadow_count = 0;
   list_result_type pending_list_states [$];

   int errors            = 0;
   int burst_left        = 0;
   int holdoff_asked     = 0;
   int holdoff_done      = 0;
   int responses_checked = 0;
   int refused_total     = 0;
   int full_hits         = 0;
   int op_hits [8];

   indexed_list_engine_core #(.CAPACITY(LIST_CAP)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // apply one command to the shadow list and return what the block should answer
   function automatic list_result_type apply_list_command(input ile_pkg::op_type op,
                                                          input logic [31:0] value,
                                                          input logic [4:0] pos);
      list_result_type r;
      logic            full;
      int              p;
      r    = '0;
      full = (shadow_count >= LIST_CAP);
      p    = int'(pos);
      case (op)
         ile_pkg::OP_APPEND: begin
            if (!full) begin
               shadow_list[shadow_count] = value;
               shadow_count++;
               r.ok = 1'b1;
            end
         end
         ile_pkg::OP_PREPEND: begin
            if (!full) begin
               for (int i = shadow_count; i > 0; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[0] = value;
               shadow_count++;
               r.ok = 1'b1;
            end
         end
         ile_pkg::OP_DROP_LAST: begin
            if (shadow_count > 0) begin
               shadow_count--;
               r.ok = 1'b1;
            end
         end
         ile_pkg::OP_DROP_FRST: begin
            if (shadow_count > 0) begin
               for (int i = 0; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
               shadow_count--;
               r.ok = 1'b1;
            end
         end
         ile_pkg::OP_READ: begin
            if (p < shadow_count) begin
               r.read_value = shadow_list[p];
               r.ok = 1'b1;
            end
         end
         ile_pkg::OP_WRITE: begin
            if (p < shadow_count) begin
               shadow_list[p] = value;
               r.ok = 1'b1;
            end
         end
         ile_pkg::OP_INSERT: begin
            // insert may land one past the tail, i.e. position equal to count
            if (!full && p <= shadow_count) begin
               for (int i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[p] = value;
               shadow_count++;
               r.ok = 1'b1;
            end
         end
         default: begin
            if (p < shadow_count) begin
               for (int i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
               shadow_count--;
               r.ok = 1'b1;
            end
         end
      endcase
      // an empty list reports zero at both ends
      if (shadow_count > 0) begin
         r.head_value = shadow_list[0];
         r.tail_value = shadow_list[shadow_count-1];
      end
      r.entry_count = shadow_count[4:0];
      return r;
   endfunction

   // offer one request; the sender runs in bursts with idle gaps in between
   // valid stays high across back-to-back requests and is only lowered for a gap
   task automatic send_command(input ile_pkg::op_type op, input logic [31:0] value,
                               input logic [4:0] pos);
      int              gap;
      list_result_type predicted;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pos, value, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // accepted at this edge: predict now so the shadow list follows request order
      predicted = apply_list_command(op, value, pos);
      pending_list_states.push_back(predicted);
      op_hits[op]++;
      if (!predicted.ok) refused_total++;
      if (shadow_count == LIST_CAP) full_hits++;
      burst_left--;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   // response checker: every accepted response is matched against the oldest prediction
   always @(posedge clock) begin : rsp_check
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_list_states.size() == 0) begin
            errors++;
            $display("%0t: response with nothing pending, expected none actual %h ok %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = pending_list_states.pop_front();
            check_field("ok", {31'd0, want.ok}, {31'd0, rsp_tuser});
            check_field("read_value", want.read_value, rsp_tdata[31:0]);
            check_field("head_value", want.head_value, rsp_tdata[63:32]);
            check_field("tail_value", want.tail_value, rsp_tdata[95:64]);
            check_field("entry_count", {27'd0, want.entry_count}, {27'd0, rsp_tdata[100:96]});
            responses_checked++;
         end
      end
   end

   // receiver: switches between stall patterns of random length, and honors a
   // requested long hold-off that it counts down itself
   initial begin : rsp_side
      int mode;
      int run_left;
      int hold_left;
      mode      = 0;
      run_left  = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (holdoff_done != holdoff_asked) begin
            holdoff_done++;
            hold_left = HOLDOFF_LEN - 1;
            rsp_tready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               mode     = $urandom_range(0, 3);
               run_left = $urandom_range(10, 60);
            end
            run_left--;
            case (mode)
               0: rsp_tready <= 1'b1;                             // no stalls
               1: rsp_tready <= ($urandom_range(0, 1) == 1);      // half the time
               2: rsp_tready <= ($urandom_range(0, 4) == 0);      // mostly stalled
               default: rsp_tready <= run_left[0];                 // alternating ready and stalled
            endcase
         end
      end
   end

   // empty list: every refusal case on an empty list, then the first insert
   task automatic test_empty_list();
      while (shadow_count > 0) send_command(ile_pkg::OP_DROP_FRST, '0, '0);
      send_command(ile_pkg::OP_DROP_LAST, 32'h1234_5678, 5'd0);
      send_command(ile_pkg::OP_DROP_FRST, 32'h1234_5678, 5'd0);
      send_command(ile_pkg::OP_READ,      32'h0,         5'd0);
      send_command(ile_pkg::OP_WRITE,     32'hDEAD_BEEF, 5'd0);
      send_command(ile_pkg::OP_REMOVE,    32'h0,         5'd0);
      send_command(ile_pkg::OP_INSERT,    32'h5555_5555, 5'd1);   // past the end of an empty list
      send_command(ile_pkg::OP_INSERT,    32'h8000_0000, 5'd0);   // first element through insert
   endtask

   // value and position extremes, and every command taking effect at least once
   task automatic test_field_extremes();
      send_command(ile_pkg::OP_APPEND,    32'h7FFF_FFFF, 5'd31);
      send_command(ile_pkg::OP_PREPEND,   32'hFFFF_FFFF, 5'd0);
      send_command(ile_pkg::OP_APPEND,    32'h0000_0000, 5'd0);
      send_command(ile_pkg::OP_INSERT,    32'h0000_0001, 5'(shadow_count));  // at the tail
      send_command(ile_pkg::OP_READ,      32'hFFFF_FFFF, 5'd31);             // out of range
      send_command(ile_pkg::OP_READ,      32'h0,         5'd0);
      send_command(ile_pkg::OP_READ,      32'h0,         5'(shadow_count - 1));
      send_command(ile_pkg::OP_WRITE,     32'h8000_0000, 5'd1);
      send_command(ile_pkg::OP_REMOVE,    32'h0,         5'd1);
      send_command(ile_pkg::OP_REMOVE,    32'h0,         5'd31);
      send_command(ile_pkg::OP_DROP_FRST, 32'h0,         5'd0);
      send_command(ile_pkg::OP_DROP_LAST, 32'h0,         5'd0);
   endtask

   // full list: growing commands refused, then shrink at both ends and insert at the front
   task automatic test_full_list();
      while (shadow_count < LIST_CAP)
         send_command(ile_pkg::OP_APPEND, $urandom, 5'($urandom));
      send_command(ile_pkg::OP_APPEND,  32'hAAAA_AAAA, 5'd0);
      send_command(ile_pkg::OP_PREPEND, 32'hAAAA_AAAA, 5'd0);
      send_command(ile_pkg::OP_INSERT,  32'hAAAA_AAAA, 5'd3);
      send_command(ile_pkg::OP_READ,    32'h0,         5'(LIST_CAP - 1));
      send_command(ile_pkg::OP_REMOVE,  32'h0,         5'(LIST_CAP - 1));
      send_command(ile_pkg::OP_REMOVE,  32'h0,         5'd0);
      send_command(ile_pkg::OP_INSERT,  32'h0F0F_0F0F, 5'd0);   // shifts every entry of the list
   endtask

   // backpressure: the receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      holdoff_asked++;
      repeat (40)
         send_command(ile_pkg::op_type'($urandom_range(0, 7)), $urandom,
                      5'($urandom_range(0, 16)));
   endtask

   // random traffic: alternating growing and shrinking phases keep the list moving
   // between empty and full; most positions are in range, some are anywhere
   task automatic test_random_traffic(input int n_cmds);
      logic            growing;
      int              phase_left;
      int              roll;
      ile_pkg::op_type op;
      logic [31:0]     value;
      logic [4:0]      pos;
      growing    = 1'b1;
      phase_left = 0;
      for (int n = 0; n < n_cmds; n++) begin
         if (phase_left == 0) begin
            growing    = ~growing;
            phase_left = $urandom_range(20, 80);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (growing) begin
            if      (roll < 20) op = ile_pkg::OP_APPEND;
            else if (roll < 35) op = ile_pkg::OP_PREPEND;
            else if (roll < 60) op = ile_pkg::OP_INSERT;
            else if (roll < 75) op = ile_pkg::OP_READ;
            else if (roll < 85) op = ile_pkg::OP_WRITE;
            else if (roll < 90) op = ile_pkg::OP_DROP_LAST;
            else if (roll < 95) op = ile_pkg::OP_DROP_FRST;
            else                op = ile_pkg::OP_REMOVE;
         end else begin
            if      (roll < 20) op = ile_pkg::OP_DROP_LAST;
            else if (roll < 40) op = ile_pkg::OP_DROP_FRST;
            else if (roll < 65) op = ile_pkg::OP_REMOVE;
            else if (roll < 78) op = ile_pkg::OP_READ;
            else if (roll < 88) op = ile_pkg::OP_WRITE;
            else if (roll < 92) op = ile_pkg::OP_APPEND;
            else if (roll < 96) op = ile_pkg::OP_PREPEND;
            else                op = ile_pkg::OP_INSERT;
         end
         // values: mostly random, sometimes the signed extremes
         case ($urandom_range(0, 19))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'hFFFF_FFFF;
            3:       value = 32'h0000_0000;
            default: value = $urandom;
         endcase
         if ($urandom_range(0, 99) < 15)
            pos = 5'($urandom_range(0, 31));
         else if (op == ile_pkg::OP_INSERT)
            pos = 5'($urandom_range(0, shadow_count));
         else if (shadow_count > 0)
            pos = 5'($urandom_range(0, shadow_count - 1));
         else
            pos = 5'd0;
         send_command(op, value, pos);
      end
   endtask

   initial begin : main_seq
      int guard;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_field_extremes();
      test_full_list();
      test_backpressure();
      test_random_traffic(1100);

      // stop offering, let every pending response come back, then settle
      req_tvalid <= 1'b0;
      guard = 0;
      while (pending_list_states.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (pending_list_states.size() != 0) begin
         errors++;
         $display("%0t: %0d responses never arrived, expected 0 pending actual %0d",
                  $time, pending_list_states.size(), pending_list_states.size());
      end
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("covered: append %0d prepend %0d drop-last %0d drop-first %0d read %0d",
               op_hits[ile_pkg::OP_APPEND], op_hits[ile_pkg::OP_PREPEND],
               op_hits[ile_pkg::OP_DROP_LAST], op_hits[ile_pkg::OP_DROP_FRST],
               op_hits[ile_pkg::OP_READ]);
      $display("overwrite %0d insert %0d remove %0d, %0d refused, full %0d times, %0d checked",
               op_hits[ile_pkg::OP_WRITE], op_hits[ile_pkg::OP_INSERT],
               op_hits[ile_pkg::OP_REMOVE], refused_total, full_hits, responses_checked);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
